### design/rbi_pkg.sv
package rbi_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int NZL_W     = 16;
    localparam int NUM_FACES = 6;
    localparam int DIV_BITS  = 32;
    localparam int TOL_Q     = 10;

    // pipeline stage map
    localparam int STAGE_IN   = 0;
    localparam int STAGE_PREP = 1;
    localparam int STAGE_T    = STAGE_PREP + DIV_BITS + 1;
    localparam int STAGE_MUL  = STAGE_T + 1;
    localparam int STAGE_CHK  = STAGE_MUL + 1;
    localparam int STAGE_OUT  = STAGE_CHK + 1;
    localparam int NUM_STAGES = STAGE_OUT + 1;

    localparam logic [NZL_W-1:0] NZL_RESET = 16'd66;

    typedef logic signed [DATA_W-1:0] coord_t;
    typedef logic [2:0][DATA_W-1:0] vec_t;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5,
        REG_NZL   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] min_x;
        logic [DATA_W-1:0] min_y;
        logic [DATA_W-1:0] min_z;
        logic [DATA_W-1:0] max_x;
        logic [DATA_W-1:0] max_y;
        logic [DATA_W-1:0] max_z;
        logic [NZL_W-1:0]  nzl;
    } cfg_t;

    // divider side info that rides along with the partial remainder
    typedef struct packed {
        logic [DATA_W-1:0] den;
        logic              neg;
        logic              ovf;
        logic              nz;
        logic              par;
    } div_ctl_t;

    typedef struct packed {
        logic              nz;
        logic              par;
        logic              in_box;
        logic [DATA_W-1:0] t;
    } face_res_t;

    function automatic logic [DATA_W-1:0] box_lo(input cfg_t c, input logic [1:0] ax);
        logic [DATA_W-1:0] r;
        case (ax)
            2'd0:    r = c.min_x;
            2'd1:    r = c.min_y;
            default: r = c.min_z;
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] box_hi(input cfg_t c, input logic [1:0] ax);
        logic [DATA_W-1:0] r;
        case (ax)
            2'd0:    r = c.max_x;
            2'd1:    r = c.max_y;
            default: r = c.max_z;
        endcase
        return r;
    endfunction

endpackage

### design/rbi_ray_if.sv
interface rbi_ray_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    origin_x;
    logic signed [31:0]    origin_y;
    logic signed [31:0]    origin_z;
    logic signed [31:0]    dir_x;
    logic signed [31:0]    dir_y;
    logic signed [31:0]    dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

### design/rbi_result_if.sv
interface rbi_result_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] hit_distance;

    modport source (output valid, hit, hit_distance, input ready);
    modport sink   (input valid, hit, hit_distance, output ready);
endinterface

### design/rbi_cfg_if.sv
interface rbi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/ray_box_intersection.sv
// Ray versus axis-aligned box, signed Q16.16, fully pipelined.
// One ray per cycle unless stalled; six face lanes each run a 32-stage divider.
// Stalls back up stage by stage; empty stages keep filling while output waits.
// Reset (rst_n low, async) empties the pipeline and loads the box registers
// with zero and the near-zero limit with 66.
module ray_box_intersection (
    input  logic          clk,
    input  logic          rst_n,
    rbi_ray_if.sink       ray,
    rbi_result_if.source  result,
    rbi_cfg_if.sink       cfg
);

    localparam int NS = rbi_pkg::NUM_STAGES;
    localparam int NF = rbi_pkg::NUM_FACES;

    // ------------------------------------------------------------------
    // Configuration registers: always ready, unknown indexes are dropped.
    // ------------------------------------------------------------------
    rbi_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // box corners to zero, near-zero limit (lowest field) to its default
            cfg_reg <= rbi_pkg::cfg_t'({{(6 * rbi_pkg::DATA_W){1'b0}}, rbi_pkg::NZL_RESET});
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rbi_pkg::REG_MIN_X: cfg_reg.min_x <= cfg.data;
                rbi_pkg::REG_MIN_Y: cfg_reg.min_y <= cfg.data;
                rbi_pkg::REG_MIN_Z: cfg_reg.min_z <= cfg.data;
                rbi_pkg::REG_MAX_X: cfg_reg.max_x <= cfg.data;
                rbi_pkg::REG_MAX_Y: cfg_reg.max_y <= cfg.data;
                rbi_pkg::REG_MAX_Z: cfg_reg.max_z <= cfg.data;
                rbi_pkg::REG_NZL:   cfg_reg.nzl   <= cfg.data[rbi_pkg::NZL_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage advance. A stage may load when it is
    // empty or when the stage after it advances, so bubbles collapse.
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS:0]   en_w;

    always_comb
    begin
        en_w[NS] = result.ready;
        for (int k = NS - 1; k >= 0; k--)
            en_w[k] = !valid_reg[k] || en_w[k+1];
    end

    assign ray.ready = en_w[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en_w[0])
                valid_reg[0] <= ray.valid;
            for (int k = 1; k < NS; k++)
                if (en_w[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Ray payload delay line: directions feed the multipliers, origins
    // feed the hit-point adders.
    // ------------------------------------------------------------------
    rbi_pkg::vec_t org_reg [rbi_pkg::STAGE_MUL+1];
    rbi_pkg::vec_t dir_reg [rbi_pkg::STAGE_MUL+1];

    always_ff @(posedge clk)
    begin
        if (en_w[rbi_pkg::STAGE_IN])
        begin
            org_reg[0] <= {ray.origin_z, ray.origin_y, ray.origin_x};
            dir_reg[0] <= {ray.dir_z, ray.dir_y, ray.dir_x};
        end
        for (int k = 1; k <= rbi_pkg::STAGE_MUL; k++)
            if (en_w[k])
            begin
                org_reg[k] <= org_reg[k-1];
                dir_reg[k] <= dir_reg[k-1];
            end
    end

    // ------------------------------------------------------------------
    // One lane per face, in order minus-x, plus-x, minus-y, plus-y,
    // minus-z, plus-z.
    // ------------------------------------------------------------------
    rbi_pkg::face_res_t face_res [NF];

    for (genvar f = 0; f < NF; f++)
    begin : g_face
        rbi_face u_face (
            .clk      (clk),
            .face_id  (3'(f)),
            .stage_en (en_w[NS-1:0]),
            .cfg_q    (cfg_reg),
            .org_in   (org_reg[0]),
            .dir_in   (dir_reg[0]),
            .dir_mul  (dir_reg[rbi_pkg::STAGE_T]),
            .org_chk  (org_reg[rbi_pkg::STAGE_MUL]),
            .res      (face_res[f])
        );
    end

    // ------------------------------------------------------------------
    // Face scan in order: origin on a plane stops with a hit, a parallel
    // face is skipped, otherwise its t becomes the reported distance and
    // a non-negative t whose point lies inside the others stops with a hit.
    // ------------------------------------------------------------------
    logic                       hit_next;
    logic [rbi_pkg::DATA_W-1:0] dist_next;
    logic                       hit_reg;
    logic [rbi_pkg::DATA_W-1:0] dist_reg;

    always_comb
    begin
        logic done;
        done      = 1'b0;
        hit_next  = 1'b0;
        dist_next = '0;
        for (int i = 0; i < NF; i++)
        begin
            if (!done)
            begin
                if (face_res[i].nz)
                begin
                    hit_next = 1'b1;
                    done     = 1'b1;
                end
                else if (!face_res[i].par)
                begin
                    dist_next = face_res[i].t;
                    if (!face_res[i].t[rbi_pkg::DATA_W-1] && face_res[i].in_box)
                    begin
                        hit_next = 1'b1;
                        done     = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_w[rbi_pkg::STAGE_OUT])
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign result.valid        = valid_reg[rbi_pkg::STAGE_OUT];
    assign result.hit          = hit_reg;
    assign result.hit_distance = dist_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input side only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !ray.ready |-> ((&valid_reg) && !result.ready))
        else $error("input stalled with room in the pipeline");

    // a beat in the first stage moves on whenever the second stage loads
    a_first_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && en_w[1]) |=> valid_reg[1])
        else $error("beat dropped between first stages");

    // a waiting result is neither dropped nor replaced
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && $stable(dist_reg)
                                             && $stable(hit_reg)))
        else $error("waiting result changed");

endmodule

### design/rbi_face.sv
module rbi_face (
    input  logic                               clk,
    input  logic [2:0]                         face_id,
    input  logic [rbi_pkg::NUM_STAGES-1:0]     stage_en,
    input  rbi_pkg::cfg_t                      cfg_q,
    input  rbi_pkg::vec_t                      org_in,
    input  rbi_pkg::vec_t                      dir_in,
    input  rbi_pkg::vec_t                      dir_mul,
    input  rbi_pkg::vec_t                      org_chk,
    output rbi_pkg::face_res_t                 res
);

    localparam int DW = rbi_pkg::DATA_W;
    localparam int RW = DW + 1 + rbi_pkg::FRAC_W;   // remainder width
    localparam int DB = rbi_pkg::DIV_BITS;

    // ---------------- prep: plane value, cosine, magnitudes
    logic [1:0]         axis;
    logic               plus;
    logic signed [32:0] c33;
    logic signed [32:0] dist33;
    logic [32:0]        abs_c;
    logic [32:0]        abs_dist;
    logic [DW-1:0]      lo;
    logic [DW-1:0]      hi;
    rbi_pkg::div_ctl_t  prep_ctl;

    always_comb
    begin
        axis   = face_id[2:1];
        plus   = face_id[0];
        lo     = rbi_pkg::box_lo(cfg_q, axis);
        hi     = rbi_pkg::box_hi(cfg_q, axis);
        c33    = plus ? -{dir_in[axis][DW-1], dir_in[axis]}
                      :  {dir_in[axis][DW-1], dir_in[axis]};
        dist33 = plus ? {hi[DW-1], hi} - {org_in[axis][DW-1], org_in[axis]}
                      : {org_in[axis][DW-1], org_in[axis]} - {lo[DW-1], lo};
        abs_c    = c33[32] ? -c33 : c33;
        abs_dist = dist33[32] ? -dist33 : dist33;
        prep_ctl.den = abs_c[DW-1:0];
        prep_ctl.nz  = abs_dist < {17'd0, cfg_q.nzl};
        prep_ctl.par = (abs_c < {17'd0, cfg_q.nzl}) || (c33 == 33'sd0);
        prep_ctl.neg = (!dist33[32] && (dist33 != 33'sd0)) ^ c33[32];
        prep_ctl.ovf = {15'd0, abs_dist} >= {abs_c[DW-1:0], 16'd0};
    end

    logic [RW-1:0]     rem_reg [DB+1];
    logic [DW-1:0]     q_reg   [DB+1];
    rbi_pkg::div_ctl_t ctl_reg [DB+1];

    always_ff @(posedge clk)
    begin
        if (stage_en[rbi_pkg::STAGE_PREP])
        begin
            rem_reg[0] <= {abs_dist, 16'd0};
            q_reg[0]   <= '0;
            ctl_reg[0] <= prep_ctl;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage
    for (genvar s = 1; s <= DB; s++)
    begin : g_div
        localparam int B = DB - s;
        logic [64:0]   diff;
        logic [DW-1:0] q_next;

        always_comb
        begin
            diff   = {16'd0, rem_reg[s-1]} - ({33'd0, ctl_reg[s-1].den} << B);
            q_next = q_reg[s-1];
            q_next[B] = !diff[64];
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[rbi_pkg::STAGE_PREP + s])
            begin
                rem_reg[s] <= diff[64] ? rem_reg[s-1] : diff[RW-1:0];
                q_reg[s]   <= q_next;
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    // ---------------- saturate distance
    logic [DW-1:0]     t_next;
    logic [DW-1:0]     q_fin;
    rbi_pkg::div_ctl_t ctl_fin;
    logic [DW-1:0]     t_reg;
    logic              t_nz_reg;
    logic              t_par_reg;

    always_comb
    begin
        q_fin   = q_reg[DB];
        ctl_fin = ctl_reg[DB];
        if (!ctl_fin.neg)
            t_next = (ctl_fin.ovf || q_fin[DW-1]) ? {1'b0, {(DW-1){1'b1}}} : q_fin;
        else if (ctl_fin.ovf || (q_fin[DW-1] && (q_fin[DW-2:0] != '0)))
            t_next = {1'b1, {(DW-1){1'b0}}};
        else
            t_next = -q_fin;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[rbi_pkg::STAGE_T])
        begin
            t_reg     <= t_next;
            t_nz_reg  <= ctl_fin.nz;
            t_par_reg <= ctl_fin.par;
        end
    end

    // ---------------- t * dir per axis
    logic signed [63:0] prod_reg [3];
    logic [DW-1:0]      m_t_reg;
    logic               m_nz_reg;
    logic               m_par_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[rbi_pkg::STAGE_MUL])
        begin
            for (int a = 0; a < 3; a++)
                prod_reg[a] <= $signed(t_reg) * $signed(dir_mul[a]);
            m_t_reg   <= t_reg;
            m_nz_reg  <= t_nz_reg;
            m_par_reg <= t_par_reg;
        end
    end

    // ---------------- hit point against the other five planes
    logic signed [48:0] pt [3];
    logic               inside_next;

    always_comb
    begin
        logic signed [50:0] margin;
        logic [DW-1:0]      plo;
        logic [DW-1:0]      phi;
        for (int a = 0; a < 3; a++)
            pt[a] = {prod_reg[a][63], prod_reg[a][63:16]}
                  + {{17{org_chk[a][DW-1]}}, org_chk[a]};
        inside_next = 1'b1;
        for (int j = 0; j < rbi_pkg::NUM_FACES; j++)
        begin
            plo = rbi_pkg::box_lo(cfg_q, 2'(j / 2));
            phi = rbi_pkg::box_hi(cfg_q, 2'(j / 2));
            if (j % 2 == 0)
                margin = {{2{pt[j/2][48]}}, pt[j/2]} - {{19{plo[DW-1]}}, plo};
            else
                margin = {{19{phi[DW-1]}}, phi} - {{2{pt[j/2][48]}}, pt[j/2]};
            margin = margin + 51'(rbi_pkg::TOL_Q);
            if ((3'(j) != face_id) && margin[50])
                inside_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[rbi_pkg::STAGE_CHK])
        begin
            res.in_box <= inside_next;
            res.t      <= m_t_reg;
            res.nz     <= m_nz_reg;
            res.par    <= m_par_reg;
        end
    end

endmodule
